>>> rtl/core/bwu_pkg.sv
// ----------------------------------------------------------------------------
// bwu_pkg
// Shared widths, codes and types for the breakpoint/watchpoint unit.
// ----------------------------------------------------------------------------
package bwu_pkg;

  localparam int BP_ENTRIES_DEF = 16;
  localparam int WP_ENTRIES_DEF = 16;

  localparam int ADDR_W  = 32;
  localparam int LEN_W   = 17;
  localparam int SIZE_W  = 3;
  localparam int CLASS_W = 2;
  localparam int WP_W    = CLASS_W + LEN_W + ADDR_W;

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_FETCH  = 2'd2,
    OP_ACCESS = 2'd3
  } op_t;

  localparam logic [CLASS_W-1:0] KIND_BP      = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_WRITE  = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_READ   = 2'd2;
  localparam logic [CLASS_W-1:0] CLASS_ACCESS = 2'd3;

  // compare results for one scanned entry
  typedef struct packed {
    logic bp_eq;
    logic wp_eq;
    logic acc;
    logic dir;
  } match_t;

  // one result transaction
  typedef struct packed {
    logic status;
    logic step_hit;
    logic breakpoint_hit;
    logic access_watch_hit;
    logic dir_watch_hit;
  } result_t;

endpackage

>>> rtl/core/bwu_ram.sv
// ----------------------------------------------------------------------------
// bwu_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bwu_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/bwu_match.sv
// ----------------------------------------------------------------------------
// bwu_match
// Compare stage: checks one breakpoint and one watchpoint entry against the
// current item.
// ----------------------------------------------------------------------------
module bwu_match import bwu_pkg::*; (
  input  logic [ADDR_W-1:0]  addr,
  input  logic [LEN_W-1:0]   wlen,
  input  logic [CLASS_W-1:0] kind,
  input  logic [ADDR_W:0]    acc_hi,
  input  logic               size_nz,
  input  logic               is_wr,
  input  logic               bp_vld,
  input  logic [ADDR_W-1:0]  bp_rdata,
  input  logic               wp_vld,
  input  logic [WP_W-1:0]    wp_rdata,
  output match_t             match
);

  logic [ADDR_W-1:0]  wa;
  logic [LEN_W-1:0]   wl;
  logic [CLASS_W-1:0] wc;
  logic [ADDR_W:0]    w_hi;
  logic               overlap;
  logic [CLASS_W-1:0] dir_class;

  assign {wc, wl, wa} = wp_rdata;

  // inclusive end of the watched range, no wrap past the top
  assign w_hi = {1'b0, wa} + {{(ADDR_W+1-LEN_W){1'b0}}, wl} - {{ADDR_W{1'b0}}, 1'b1};

  assign overlap = (wl != '0) && size_nz &&
                   ({1'b0, addr} <= w_hi) && ({1'b0, wa} <= acc_hi);

  assign dir_class = is_wr ? CLASS_WRITE : CLASS_READ;

  assign match.bp_eq = bp_vld && (bp_rdata == addr);
  assign match.wp_eq = wp_vld && (wa == addr) && (wl == wlen) && (wc == kind);
  assign match.acc   = wp_vld && (wc == CLASS_ACCESS) && overlap;
  assign match.dir   = wp_vld && (wc == dir_class) && overlap;

endmodule

>>> rtl/core/bwu_seq.sv
// ----------------------------------------------------------------------------
// bwu_seq
// Scan sequencer: captures an item, walks the entry tables one entry per
// cycle, updates the valid bits and builds the result.
// ----------------------------------------------------------------------------
module bwu_seq import bwu_pkg::*; #(
  parameter int BP_ENTRIES = BP_ENTRIES_DEF,
  parameter int WP_ENTRIES = WP_ENTRIES_DEF,
  localparam int BIW = (BP_ENTRIES > 1) ? $clog2(BP_ENTRIES) : 1,
  localparam int WIW = (WP_ENTRIES > 1) ? $clog2(WP_ENTRIES) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         op,
  input  logic [CLASS_W-1:0] kind,
  input  logic [ADDR_W-1:0]  address,
  input  logic [LEN_W-1:0]   watch_length,
  input  logic [SIZE_W-1:0]  access_size,
  input  logic               is_write,
  input  logic               step_mode,
  output logic               bp_we,
  output logic [BIW-1:0]     bp_addr,
  output logic [ADDR_W-1:0]  bp_wdata,
  input  logic [ADDR_W-1:0]  bp_rdata,
  output logic               wp_we,
  output logic [WIW-1:0]     wp_addr,
  output logic [WP_W-1:0]    wp_wdata,
  input  logic [WP_W-1:0]    wp_rdata,
  input  logic               out_free,
  output logic               res_valid,
  output result_t            res
);

  localparam int SW = (BIW > WIW) ? BIW : WIW;
  localparam logic [SW-1:0] BP_LAST = SW'(BP_ENTRIES - 1);
  localparam logic [SW-1:0] WP_LAST = SW'(WP_ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;

  op_t                op_q;
  logic [CLASS_W-1:0] kind_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [LEN_W-1:0]   wlen_q;
  logic [ADDR_W:0]    acc_hi;
  logic               size_nz;
  logic               wr_q;
  logic               step_q;

  logic [SW-1:0]      idx;
  logic               issue;
  logic               cmp_vld;
  logic [SW-1:0]      cmp_idx;
  logic               acc_acc;
  logic               dir_acc;

  logic [BP_ENTRIES-1:0] bp_valid;
  logic [WP_ENTRIES-1:0] wp_valid;

  logic          use_bp;
  logic [SW-1:0] last;
  match_t        match;
  logic          done_now;
  result_t       res_next;
  logic          bp_set;
  logic          wp_set;
  logic          bp_clr;
  logic          wp_clr;
  logic          hit_bp;

  assign use_bp = (op_q == OP_FETCH) ||
                  ((op_q == OP_SET || op_q == OP_CLEAR) && kind_q == KIND_BP);
  assign last   = use_bp ? BP_LAST : WP_LAST;

  bwu_match u_match (
    .addr     (addr_q),
    .wlen     (wlen_q),
    .kind     (kind_q),
    .acc_hi   (acc_hi),
    .size_nz  (size_nz),
    .is_wr    (wr_q),
    .bp_vld   (bp_valid[cmp_idx[BIW-1:0]]),
    .bp_rdata (bp_rdata),
    .wp_vld   (wp_valid[cmp_idx[WIW-1:0]]),
    .wp_rdata (wp_rdata),
    .match    (match)
  );

  always_comb begin
    done_now = 1'b0;
    res_next = '0;
    bp_set   = 1'b0;
    wp_set   = 1'b0;
    bp_clr   = 1'b0;
    wp_clr   = 1'b0;
    hit_bp   = 1'b0;
    if (state == S_SCAN) begin
      if (op_q == OP_SET) begin
        // lowest free slot, one slot a cycle
        if (use_bp && !bp_valid[idx[BIW-1:0]]) begin
          bp_set   = 1'b1;
          done_now = 1'b1;
        end else if (!use_bp && !wp_valid[idx[WIW-1:0]]) begin
          wp_set   = 1'b1;
          done_now = 1'b1;
        end else if (idx == last) begin
          res_next.status = 1'b1;
          done_now        = 1'b1;
        end
      end else if (cmp_vld) begin
        hit_bp = (op_q == OP_FETCH) && match.bp_eq;
        bp_clr = (op_q == OP_CLEAR) && use_bp && match.bp_eq;
        wp_clr = (op_q == OP_CLEAR) && !use_bp && match.wp_eq;
        res_next.step_hit         = (op_q == OP_FETCH) && step_q;
        res_next.breakpoint_hit   = hit_bp;
        res_next.access_watch_hit = acc_acc || ((op_q == OP_ACCESS) && match.acc);
        res_next.dir_watch_hit    = dir_acc || ((op_q == OP_ACCESS) && match.dir);
        done_now = (cmp_idx == last) || hit_bp || bp_clr || wp_clr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      issue    <= 1'b0;
      cmp_vld  <= 1'b0;
      bp_valid <= '0;
      wp_valid <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state   <= S_SCAN;
            idx     <= '0;
            issue   <= 1'b1;
            cmp_vld <= 1'b0;
            acc_acc <= 1'b0;
            dir_acc <= 1'b0;
          end
        end
        S_SCAN: begin
          if (bp_set) bp_valid[idx[BIW-1:0]] <= 1'b1;
          if (wp_set) wp_valid[idx[WIW-1:0]] <= 1'b1;
          if (bp_clr) bp_valid[cmp_idx[BIW-1:0]] <= 1'b0;
          if (wp_clr) wp_valid[cmp_idx[WIW-1:0]] <= 1'b0;
          if (done_now) begin
            state   <= S_DONE;
            res     <= res_next;
            issue   <= 1'b0;
            cmp_vld <= 1'b0;
          end else if (op_q == OP_SET) begin
            idx <= idx + 1'b1;
          end else begin
            // read issue one entry ahead of the compare stage
            cmp_vld <= issue;
            cmp_idx <= idx;
            if (issue) begin
              if (idx == last) issue <= 1'b0;
              else idx <= idx + 1'b1;
            end
            if (cmp_vld) begin
              acc_acc <= res_next.access_watch_hit;
              dir_acc <= res_next.dir_watch_hit;
            end
          end
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // item capture, payload only
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op_q    <= op_t'(op);
      kind_q  <= kind;
      addr_q  <= address;
      wlen_q  <= watch_length;
      acc_hi  <= {1'b0, address} + {{(ADDR_W+1-SIZE_W){1'b0}}, access_size}
                 - {{ADDR_W{1'b0}}, 1'b1};
      size_nz <= (access_size != '0);
      wr_q    <= is_write;
      step_q  <= step_mode;
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign res_valid = (state == S_DONE);

  assign bp_we    = bp_set;
  assign bp_addr  = idx[BIW-1:0];
  assign bp_wdata = addr_q;
  assign wp_we    = wp_set;
  assign wp_addr  = idx[WIW-1:0];
  assign wp_wdata = {kind_q, wlen_q, addr_q};

endmodule

>>> rtl/core/breakpoint_watchpoint_unit_core.sv
// ----------------------------------------------------------------------------
// breakpoint_watchpoint_unit_core
// Debug match unit: breakpoint and watchpoint tables with set, clear,
// fetch check and memory access check transactions.
// ----------------------------------------------------------------------------
// Timing: one transaction is taken at a time and yields exactly one result
// transaction. Fetch, access and clear checks walk the table one entry per
// cycle through the table RAM's registered read port, and a scan ends
// before the next transaction is accepted.
// Set walks the valid bits for the lowest free slot and stops there; clear
// stops at the first exact match and fetch at the first breakpoint hit.
// A finished result waits in an output register, so the next transaction
// is accepted while that result is still stalled. Valid bits reset to zero
// at once; no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module breakpoint_watchpoint_unit_core import bwu_pkg::*; #(
  parameter int BP_ENTRIES = BP_ENTRIES_DEF,
  parameter int WP_ENTRIES = WP_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // input transactions
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         op,
  input  logic [CLASS_W-1:0] kind,
  input  logic [ADDR_W-1:0]  address,
  input  logic [LEN_W-1:0]   watch_length,
  input  logic [SIZE_W-1:0]  access_size,
  input  logic               is_write,
  input  logic               step_mode,
  // result transactions
  output logic               out_valid,
  input  logic               out_stall,
  output logic               status,
  output logic               step_hit,
  output logic               breakpoint_hit,
  output logic               access_watch_hit,
  output logic               dir_watch_hit
);

  localparam int BIW = (BP_ENTRIES > 1) ? $clog2(BP_ENTRIES) : 1;
  localparam int WIW = (WP_ENTRIES > 1) ? $clog2(WP_ENTRIES) : 1;

  // table RAM ports, read and write share the scan index
  logic              bp_we;
  logic [BIW-1:0]    bp_addr;
  logic [ADDR_W-1:0] bp_wdata;
  logic [ADDR_W-1:0] bp_rdata;
  logic              wp_we;
  logic [WIW-1:0]    wp_addr;
  logic [WP_W-1:0]   wp_wdata;
  logic [WP_W-1:0]   wp_rdata;

  logic    out_free;
  logic    res_valid;
  result_t res;
  result_t out_q;

  // breakpoint addresses
  bwu_ram #(
    .DEPTH (BP_ENTRIES),
    .WIDTH (ADDR_W)
  ) u_bp_ram (
    .clk   (clk),
    .we    (bp_we),
    .waddr (bp_addr),
    .wdata (bp_wdata),
    .raddr (bp_addr),
    .rdata (bp_rdata)
  );

  // watchpoints: class, length, address
  bwu_ram #(
    .DEPTH (WP_ENTRIES),
    .WIDTH (WP_W)
  ) u_wp_ram (
    .clk   (clk),
    .we    (wp_we),
    .waddr (wp_addr),
    .wdata (wp_wdata),
    .raddr (wp_addr),
    .rdata (wp_rdata)
  );

  bwu_seq #(
    .BP_ENTRIES (BP_ENTRIES),
    .WP_ENTRIES (WP_ENTRIES)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .kind         (kind),
    .address      (address),
    .watch_length (watch_length),
    .access_size  (access_size),
    .is_write     (is_write),
    .step_mode    (step_mode),
    .bp_we        (bp_we),
    .bp_addr      (bp_addr),
    .bp_wdata     (bp_wdata),
    .bp_rdata     (bp_rdata),
    .wp_we        (wp_we),
    .wp_addr      (wp_addr),
    .wp_wdata     (wp_wdata),
    .wp_rdata     (wp_rdata),
    .out_free     (out_free),
    .res_valid    (res_valid),
    .res          (res)
  );

  // output register frees up when empty or being taken this cycle
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      out_q <= res;
    end
  end

  assign status           = out_q.status;
  assign step_hit         = out_q.step_hit;
  assign breakpoint_hit   = out_q.breakpoint_hit;
  assign access_watch_hit = out_q.access_watch_hit;
  assign dir_watch_hit    = out_q.dir_watch_hit;

endmodule

>>> sim/bwu_checker.sv
// ----------------------------------------------------------------------------
// bwu_checker
// Watches both channels of the breakpoint/watchpoint unit, keeps its own
// copy of the breakpoint and watchpoint tables, predicts every result and
// compares it field by field.
// ----------------------------------------------------------------------------
module bwu_checker import bwu_pkg::*; #(
  parameter int BP_ENTRIES = BP_ENTRIES_DEF,
  parameter int WP_ENTRIES = WP_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         op,
  input  logic [CLASS_W-1:0] kind,
  input  logic [ADDR_W-1:0]  address,
  input  logic [LEN_W-1:0]   watch_length,
  input  logic [SIZE_W-1:0]  access_size,
  input  logic               is_write,
  input  logic               step_mode,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               status,
  input  logic               step_hit,
  input  logic               breakpoint_hit,
  input  logic               access_watch_hit,
  input  logic               dir_watch_hit,
  output int                 fail_count,
  output int                 pending,
  output int                 full_count,
  output int                 bp_hit_count,
  output int                 watch_hit_count
);

  // shadow tables
  logic [ADDR_W-1:0]  bp_at   [BP_ENTRIES];
  logic               bp_live [BP_ENTRIES];
  logic [ADDR_W-1:0]  wp_base [WP_ENTRIES];
  logic [LEN_W-1:0]   wp_span [WP_ENTRIES];
  logic [CLASS_W-1:0] wp_kind [WP_ENTRIES];
  logic               wp_live [WP_ENTRIES];

  result_t hits_due[$];

  // inclusive byte ranges, widened so the top of the address space never wraps
  function automatic logic spans_meet(logic [ADDR_W-1:0] a_lo, logic [LEN_W-1:0] a_len,
                                      logic [ADDR_W-1:0] b_lo, logic [SIZE_W-1:0] b_len);
    logic [ADDR_W+1:0] a_hi;
    logic [ADDR_W+1:0] b_hi;
    if (a_len == '0 || b_len == '0) return 1'b0;
    a_hi = {2'b00, a_lo} + (ADDR_W+2)'(a_len) - 1;
    b_hi = {2'b00, b_lo} + (ADDR_W+2)'(b_len) - 1;
    return ({2'b00, a_lo} <= b_hi) && ({2'b00, b_lo} <= a_hi);
  endfunction

  function automatic logic watch_hit(logic [CLASS_W-1:0] cls, logic [ADDR_W-1:0] addr,
                                     logic [SIZE_W-1:0] size);
    for (int i = 0; i < WP_ENTRIES; i++) begin
      if (wp_live[i] && wp_kind[i] == cls && spans_meet(wp_base[i], wp_span[i], addr, size))
        return 1'b1;
    end
    return 1'b0;
  endfunction

  // applies one transaction to the shadow tables and returns its result
  function automatic result_t debug_outcome(op_t code, logic [CLASS_W-1:0] cls,
                                            logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len,
                                            logic [SIZE_W-1:0] size, logic wr, logic stepping);
    result_t r;
    logic    done;
    r    = '0;
    done = 1'b0;
    case (code)
      OP_SET: begin
        if (cls == KIND_BP) begin
          for (int i = 0; i < BP_ENTRIES; i++) begin
            if (!done && !bp_live[i]) begin
              bp_at[i]   = addr;
              bp_live[i] = 1'b1;
              done       = 1'b1;
            end
          end
        end else begin
          for (int i = 0; i < WP_ENTRIES; i++) begin
            if (!done && !wp_live[i]) begin
              wp_base[i] = addr;
              wp_span[i] = len;
              wp_kind[i] = cls;
              wp_live[i] = 1'b1;
              done       = 1'b1;
            end
          end
        end
        r.status = !done;
      end
      OP_CLEAR: begin
        if (cls == KIND_BP) begin
          for (int i = 0; i < BP_ENTRIES; i++) begin
            if (!done && bp_live[i] && bp_at[i] == addr) begin
              bp_live[i] = 1'b0;
              done       = 1'b1;
            end
          end
        end else begin
          for (int i = 0; i < WP_ENTRIES; i++) begin
            if (!done && wp_live[i] && wp_base[i] == addr && wp_span[i] == len &&
                wp_kind[i] == cls) begin
              wp_live[i] = 1'b0;
              done       = 1'b1;
            end
          end
        end
      end
      OP_FETCH: begin
        r.step_hit = stepping;
        for (int i = 0; i < BP_ENTRIES; i++) begin
          if (bp_live[i] && bp_at[i] == addr) r.breakpoint_hit = 1'b1;
        end
      end
      default: begin
        r.access_watch_hit = watch_hit(CLASS_ACCESS, addr, size);
        r.dir_watch_hit    = watch_hit(wr ? CLASS_WRITE : CLASS_READ, addr, size);
      end
    endcase
    return r;
  endfunction

  task automatic compare_field(input string field, input logic want, input logic got);
    if (got !== want) begin
      $error("%s mismatch: expected %0b, got %0b", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      for (int i = 0; i < BP_ENTRIES; i++) begin
        bp_at[i]   = '0;
        bp_live[i] = 1'b0;
      end
      for (int i = 0; i < WP_ENTRIES; i++) begin
        wp_base[i] = '0;
        wp_span[i] = '0;
        wp_kind[i] = '0;
        wp_live[i] = 1'b0;
      end
      hits_due.delete();
      fail_count      = 0;
      pending         = 0;
      full_count      = 0;
      bp_hit_count    = 0;
      watch_hit_count = 0;
    end else begin
      // results first, so a result never meets the expectation of this same edge
      if (out_valid && !out_stall) begin
        got = {status, step_hit, breakpoint_hit, access_watch_hit, dir_watch_hit};
        if (hits_due.size() == 0) begin
          $error("result transaction with no expectation waiting");
          fail_count++;
        end else begin
          want = hits_due.pop_front();
          compare_field("status", want.status, got.status);
          compare_field("step_hit", want.step_hit, got.step_hit);
          compare_field("breakpoint_hit", want.breakpoint_hit, got.breakpoint_hit);
          compare_field("access_watch_hit", want.access_watch_hit, got.access_watch_hit);
          compare_field("dir_watch_hit", want.dir_watch_hit, got.dir_watch_hit);
          if (want.status) full_count++;
          if (want.breakpoint_hit) bp_hit_count++;
          if (want.access_watch_hit || want.dir_watch_hit) watch_hit_count++;
        end
      end
      if (in_valid && !in_stall)
        hits_due.push_back(debug_outcome(op_t'(op), kind, address, watch_length,
                                         access_size, is_write, step_mode));
      pending = hits_due.size();
    end
  end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for breakpoint_watchpoint_unit_core. A directed part
// walks the corner cases of set, clear, fetch and access; a random part runs
// bursts of table fills, checks and clears around a small pool of addresses,
// with random gaps and stalls and one long result hold-off. bwu_checker does
// all prediction and comparison.
// ----------------------------------------------------------------------------
module testbench;
  import bwu_pkg::*;

  localparam int ITEMS       = 1850;
  localparam int CALM_ITEMS  = 150;    // tail of the run without any idling
  localparam int HOLD_AT     = 600;    // transactions sent before the long hold-off
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN       = 40;
  localparam int LIMIT       = 500000;

  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    logic [ADDR_W-1:0]  addr;
    logic [LEN_W-1:0]   len;
  } entry_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  op_t                op;
  logic [CLASS_W-1:0] kind;
  logic [ADDR_W-1:0]  address;
  logic [LEN_W-1:0]   watch_length;
  logic [SIZE_W-1:0]  access_size;
  logic               is_write;
  logic               step_mode;
  logic               out_valid;
  logic               out_stall;
  logic               status;
  logic               step_hit;
  logic               breakpoint_hit;
  logic               access_watch_hit;
  logic               dir_watch_hit;

  int fail_count;
  int pending;
  int full_count;
  int bp_hit_count;
  int watch_hit_count;

  // stimulus bookkeeping
  int     sent;
  int     n_set;
  int     n_clear;
  int     n_fetch;
  int     n_access;
  int     cycles;
  logic   calm;
  logic   sender_quiet;
  entry_t booked[$];          // entries set so far, candidates for clears
  logic [ADDR_W-1:0] pool[8]; // addresses that sets and checks cluster around

  breakpoint_watchpoint_unit_core u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .op               (op),
    .kind             (kind),
    .address          (address),
    .watch_length     (watch_length),
    .access_size      (access_size),
    .is_write         (is_write),
    .step_mode        (step_mode),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .step_hit         (step_hit),
    .breakpoint_hit   (breakpoint_hit),
    .access_watch_hit (access_watch_hit),
    .dir_watch_hit    (dir_watch_hit)
  );

  bwu_checker u_check (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .op               (op),
    .kind             (kind),
    .address          (address),
    .watch_length     (watch_length),
    .access_size      (access_size),
    .is_write         (is_write),
    .step_mode        (step_mode),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .step_hit         (step_hit),
    .breakpoint_hit   (breakpoint_hit),
    .access_watch_hit (access_watch_hit),
    .dir_watch_hit    (dir_watch_hit),
    .fail_count       (fail_count),
    .pending          (pending),
    .full_count       (full_count),
    .bp_hit_count     (bp_hit_count),
    .watch_hit_count  (watch_hit_count)
  );

  // clock, period 4
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // sends one input transaction, starting and ending at a falling edge;
  // valid stays high into the next transaction unless a gap follows
  task automatic issue(input op_t code, input logic [CLASS_W-1:0] cls,
                       input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len,
                       input logic [SIZE_W-1:0] size, input logic wr, input logic stepping);
    op           <= code;
    kind         <= cls;
    address      <= addr;
    watch_length <= len;
    access_size  <= size;
    is_write     <= wr;
    step_mode    <= stepping;
    in_valid     <= 1'b1;
    // accepted at the first rising edge without stall
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
    calm = (sent >= ITEMS - CALM_ITEMS);
    case (code)
      OP_SET:   n_set++;
      OP_CLEAR: n_clear++;
      OP_FETCH: n_fetch++;
      default:  n_access++;
    endcase
    if (code == OP_SET) begin
      booked.push_back('{cls: cls, addr: addr, len: len});
      if (booked.size() > 64) void'(booked.pop_front());
    end
    // sender gap burst
    if (!calm && !sender_quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  // watch lengths: mostly short, plus zero, 64 KiB and raw 17-bit values
  function automatic logic [LEN_W-1:0] pick_length();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 17'h10000;
      2:       return LEN_W'($urandom);
      default: return LEN_W'($urandom_range(1, 16));
    endcase
  endfunction

  // access sizes: mostly 1, 2 or 4 bytes, sometimes any 3-bit value
  function automatic logic [SIZE_W-1:0] pick_size();
    if ($urandom_range(0, 4) == 0) return SIZE_W'($urandom_range(0, 7));
    return SIZE_W'(1 << $urandom_range(0, 2));
  endfunction

  // an address close to one of the pool addresses, wrapping at either end
  function automatic logic [ADDR_W-1:0] near_pool();
    return pool[$urandom_range(0, 7)] + ADDR_W'($urandom_range(0, 24)) - 32'd12;
  endfunction

  // receiver: random stall bursts, one long hold-off, nothing in the calm tail
  initial begin
    logic held;
    held      = 1'b0;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (calm) begin
        out_stall <= 1'b0;
        @(negedge clk);
      end else if (!held && sent >= HOLD_AT) begin
        // long hold-off so the result register fills and input backs up
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 30)) @(negedge clk);
      end
    end
  end

  // main stimulus
  initial begin
    entry_t e;
    int     idx;
    int     burst;
    logic   all_bp;
    // every input known from time zero
    rst          = 1'b1;
    in_valid     = 1'b0;
    op           = OP_SET;
    kind         = KIND_BP;
    address      = '0;
    watch_length = '0;
    access_size  = '0;
    is_write     = 1'b0;
    step_mode    = 1'b0;
    sent         = 0;
    n_set        = 0;
    n_clear      = 0;
    n_fetch      = 0;
    n_access     = 0;
    calm         = 1'b0;
    sender_quiet = 1'b0;
    pool[0] = 32'h0000_0000;
    pool[1] = 32'hFFFF_FFF8;
    for (int i = 2; i < 8; i++) pool[i] = $urandom;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ---- directed corner cases ----
    // breakpoints at both ends of the address space, one duplicated
    issue(OP_SET,   KIND_BP, 32'h0000_0000, '0, '0, 1'b0, 1'b0);
    issue(OP_SET,   KIND_BP, 32'hFFFF_FFFF, '0, '0, 1'b0, 1'b0);
    issue(OP_SET,   KIND_BP, 32'h0000_0000, '0, '0, 1'b0, 1'b0);
    issue(OP_FETCH, KIND_BP, 32'h0000_0000, '0, '0, 1'b0, 1'b0);
    // step mode together with a breakpoint hit, then step mode alone
    issue(OP_FETCH, KIND_BP, 32'hFFFF_FFFF, '0, '0, 1'b0, 1'b1);
    issue(OP_FETCH, KIND_BP, 32'h1234_5678, '0, '0, 1'b0, 1'b1);
    // clearing one duplicate leaves the other in place
    issue(OP_CLEAR, KIND_BP, 32'h0000_0000, '0, '0, 1'b0, 1'b0);
    issue(OP_FETCH, KIND_BP, 32'h0000_0000, '0, '0, 1'b0, 1'b0);
    // clear with no match changes nothing
    issue(OP_CLEAR, KIND_BP, 32'hDEAD_BEEF, '0, '0, 1'b0, 1'b0);
    // write watch running past the top, zero-length read watch, small access watch
    issue(OP_SET, CLASS_WRITE,  32'hFFFF_FFF0, 17'h10000, '0, 1'b0, 1'b0);
    issue(OP_SET, CLASS_READ,   32'h0000_1000, 17'h00000, '0, 1'b0, 1'b0);
    issue(OP_SET, CLASS_ACCESS, 32'h0000_2000, 17'h00004, '0, 1'b0, 1'b0);
    // the range past the top must not wrap to address zero
    issue(OP_ACCESS, KIND_BP, 32'h0000_0000, '0, 3'd4, 1'b1, 1'b0);
    issue(OP_ACCESS, KIND_BP, 32'hFFFF_FFFE, '0, 3'd7, 1'b1, 1'b0);
    issue(OP_ACCESS, KIND_BP, 32'hFFFF_FFFE, '0, 3'd4, 1'b0, 1'b0);
    // zero-length watch never hits
    issue(OP_ACCESS, KIND_BP, 32'h0000_1000, '0, 3'd1, 1'b0, 1'b0);
    // touching the first watched byte from below, and just missing it
    issue(OP_ACCESS, KIND_BP, 32'h0000_1FFD, '0, 3'd4, 1'b0, 1'b0);
    issue(OP_ACCESS, KIND_BP, 32'h0000_1FFC, '0, 3'd4, 1'b1, 1'b0);
    // zero access size never hits, odd size taken as is
    issue(OP_ACCESS, KIND_BP, 32'h0000_2003, '0, 3'd0, 1'b0, 1'b0);
    issue(OP_ACCESS, KIND_BP, 32'h0000_1FFE, '0, 3'd3, 1'b1, 1'b0);
    // clears with the wrong length or class are ignored, the exact one removes
    issue(OP_CLEAR, CLASS_ACCESS, 32'h0000_2000, 17'h00005, '0, 1'b0, 1'b0);
    issue(OP_CLEAR, CLASS_READ,   32'hFFFF_FFF0, 17'h10000, '0, 1'b0, 1'b0);
    issue(OP_CLEAR, CLASS_ACCESS, 32'h0000_2000, 17'h00004, '0, 1'b0, 1'b0);
    issue(OP_ACCESS, KIND_BP, 32'h0000_2000, '0, 3'd1, 1'b1, 1'b0);
    // all-ones watch length and noise in the unused fields
    issue(OP_SET, CLASS_READ, 32'h8000_0000, 17'h1FFFF, 3'd7, 1'b1, 1'b1);

    // ---- random bursts ----
    while (sent < ITEMS) begin
      sender_quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) pool[$urandom_range(2, 7)] = $urandom;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: begin
          // table fill: long enough to run a table full now and then
          burst  = $urandom_range(4, 20);
          all_bp = 1'($urandom_range(0, 1));
          repeat (burst) begin
            issue(OP_SET, all_bp ? KIND_BP : CLASS_W'($urandom_range(0, 3)), near_pool(),
                  pick_length(), SIZE_W'($urandom), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
          end
        end
        5, 6, 7, 8, 9, 10, 11: begin
          // fetch and access checks around the pool and the booked entries
          burst = $urandom_range(5, 30);
          repeat (burst) begin
            e.addr = near_pool();
            if (booked.size() != 0 && $urandom_range(0, 2) == 0)
              e.addr = booked[$urandom_range(0, booked.size() - 1)].addr
                       + ADDR_W'($urandom_range(0, 4)) - 32'd2;
            if ($urandom_range(0, 2) == 0)
              issue(OP_FETCH, CLASS_W'($urandom), e.addr, LEN_W'($urandom),
                    SIZE_W'($urandom), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
            else
              issue(OP_ACCESS, CLASS_W'($urandom), e.addr, LEN_W'($urandom),
                    pick_size(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          end
        end
        12, 13, 14, 15, 16: begin
          // clears of booked entries, sometimes slightly off so they miss
          burst = $urandom_range(2, 16);
          repeat (burst) begin
            if (booked.size() == 0 || $urandom_range(0, 5) == 0) begin
              issue(OP_CLEAR, CLASS_W'($urandom), near_pool(), pick_length(),
                    SIZE_W'($urandom), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
            end else begin
              idx = $urandom_range(0, booked.size() - 1);
              e   = booked[idx];
              booked.delete(idx);
              if ($urandom_range(0, 7) == 0) e.len = e.len + 1'b1;
              issue(OP_CLEAR, e.cls, e.addr, e.len, SIZE_W'($urandom),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
          end
        end
        default: begin
          // noise: every field random
          burst = $urandom_range(1, 8);
          repeat (burst) begin
            issue(op_t'($urandom_range(0, 3)), CLASS_W'($urandom), $urandom,
                  LEN_W'($urandom), SIZE_W'($urandom), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
          end
        end
      endcase
    end

    // drain: wait for every result, then for the block to settle
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);

    $display("ran %0d transactions: %0d sets, %0d clears, %0d fetches, %0d accesses",
             sent, n_set, n_clear, n_fetch, n_access);
    $display("table full on %0d sets, %0d breakpoint hits, %0d watch hits",
             full_count, bp_hit_count, watch_hit_count);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/bwu_pkg.sv
rtl/core/bwu_ram.sv
rtl/core/bwu_match.sv
rtl/core/bwu_seq.sv
rtl/core/breakpoint_watchpoint_unit_core.sv
sim/bwu_checker.sv
sim/testbench.sv
